// ----- hw/rtl/ptd_pkg.sv -----
// Shared types and constants for the periodic task dispatch timer.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int unsigned ChMax = 8;
  localparam int unsigned ChW   = 3;
  localparam int unsigned CntW  = 8;
  localparam int unsigned PinW  = 6;
  localparam int unsigned PscW  = 4;
  localparam int unsigned CfgIdxW = 4;

  typedef logic [ChMax-1:0][CntW-1:0] period_arr_t;

  // Countdown values after reset: staggered primes.
  localparam period_arr_t StartCount = {8'd19, 8'd17, 8'd13, 8'd11,
                                        8'd7,  8'd5,  8'd3,  8'd2};
  // Period register reset values.
  localparam period_arr_t PeriodRst  = {8'd60, 8'd50, 8'd40, 8'd30,
                                        8'd20, 8'd10, 8'd10, 8'd10};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } scan_state_e;

  // Access to the countdown memory.
  typedef struct packed {
    logic            rd_en;
    logic [ChW-1:0]  rd_addr;
    logic            wr_en;
    logic [ChW-1:0]  wr_addr;
    logic [CntW-1:0] wr_data;
  } mem_req_t;

  // One result beat from the scan controller.
  typedef struct packed {
    logic             valid;
    logic             scan_done;
    logic [ChMax-1:0] mask;
    logic [PinW-1:0]  pins;
  } result_t;

  typedef struct packed {
    logic busy;
  } ctrl_status_t;

endpackage

// ----- hw/rtl/ptd_cnt_mem.sv -----
// Countdown memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module ptd_cnt_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptd_pkg::mem_req_t        req_i,
  output logic [ptd_pkg::CntW-1:0] rd_data_o
);
  import ptd_pkg::*;

  logic [CntW-1:0]  mem_q [ChMax];
  logic [ChMax-1:0] vld_q;
  logic [CntW-1:0]  rd_data_q;

  // Entries not yet written read as their start value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= vld_q[req_i.rd_addr] ? mem_q[req_i.rd_addr]
                                         : StartCount[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/ptd_scan_ctrl.sv -----
// Prescaler and channel scan sequencer: read, decrement or reload, write back.
`timescale 1ns / 1ps

module ptd_scan_ctrl #(
  parameter int unsigned NUM_CHANNELS   = 8,
  parameter int unsigned TICKS_PER_SCAN = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     tick_i,
  input  logic                     slot_free_i,
  output logic                     in_stall_o,
  input  ptd_pkg::period_arr_t     period_i,
  input  logic [ptd_pkg::CntW-1:0] rd_data_i,
  output ptd_pkg::mem_req_t        req_o,
  output ptd_pkg::result_t         res_o,
  output ptd_pkg::ctrl_status_t    status_o
);
  import ptd_pkg::*;

  localparam logic [ChW:0]  NumCh = (ChW+1)'(NUM_CHANNELS);
  localparam logic [PscW:0] Tps   = (PscW+1)'(TICKS_PER_SCAN);

  scan_state_e      st_q, st_d;
  logic [PscW-1:0]  presc_q, presc_d;
  logic [ChW:0]     cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [ChW-1:0]   pidx_q, pidx_d;
  logic [ChMax-1:0] mask_q, mask_d;
  logic [PinW-1:0]  pin_q, pin_d;
  logic [PscW:0]    presc_nxt;
  logic [CntW-1:0]  dec;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      presc_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      pidx_q  <= '0;
      mask_q  <= '0;
      pin_q   <= '0;
    end else begin
      st_q    <= st_d;
      presc_q <= presc_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
      mask_q  <= mask_d;
      pin_q   <= pin_d;
    end
  end

  always_comb begin
    st_d    = st_q;
    presc_d = presc_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    mask_d  = mask_q;
    pin_d   = pin_q;
    req_o   = '0;
    res_o   = '0;
    res_o.pins = pin_q;
    presc_nxt  = {1'b0, presc_q} + (PscW+1)'(1);
    dec        = rd_data_i - CntW'(1);
    in_stall_o = (st_q != ST_IDLE) || !slot_free_i;
    accept     = in_valid_i && !in_stall_o;

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (tick_i && (presc_nxt >= Tps)) begin
            presc_d = '0;
            cnt_d   = '0;
            mask_d  = '0;
            st_d    = ST_SCAN;
          end else begin
            if (tick_i) begin
              presc_d = presc_nxt[PscW-1:0];
            end
            res_o.valid = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Issue a read for channel cnt while channel pidx is updated.
        req_o.rd_en   = (cnt_q < NumCh);
        req_o.rd_addr = cnt_q[ChW-1:0];
        pend_d        = req_o.rd_en;
        if (req_o.rd_en) begin
          pidx_d = cnt_q[ChW-1:0];
          cnt_d  = cnt_q + (ChW+1)'(1);
        end
        if (pend_q && (rd_data_i != '0)) begin
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = pidx_q;
          if (dec == '0) begin
            req_o.wr_data  = period_i[pidx_q];
            mask_d[pidx_q] = 1'b1;
            if (pidx_q >= ChW'(2)) begin
              pin_d[pidx_q - ChW'(2)] = ~pin_q[pidx_q - ChW'(2)];
            end
          end else begin
            req_o.wr_data = dec;
          end
        end
        if (!req_o.rd_en && !pend_q) begin
          st_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free_i) begin
          res_o.valid     = 1'b1;
          res_o.scan_done = 1'b1;
          res_o.mask      = mask_q;
          st_d            = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign status_o.busy = (st_q != ST_IDLE);

endmodule

// ----- hw/rtl/periodic_task_dispatch_timer.sv -----
// Top level of the periodic task dispatch timer: period registers, output register.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_stall_o / tick_i): one beat per base tick
//   slot. tick_i = 1 advances the prescaler; tick_i = 0 passes no time.
// - Output channel (out_valid_o / out_stall_i): exactly one result beat per
//   input beat, carrying scan_done_o, fired_mask_o and pin_levels_o.
// - Config channel (cfg_valid_i / cfg_ready_o): writes period register
//   cfg_index_i (0..7); indexes 8 and up are dropped. Always ready.
// Result path
// - A beat that does not end a prescale period lands in the output register
//   in the cycle after acceptance.
// - A beat that ends the period runs a scan through the countdown memory,
//   one channel read per cycle with write-back in the following cycle; the
//   result enters the output register from the finish state once the slot
//   is free. One item is in flight at a time.
// Reset: countdowns return to 2,3,5,...,19 (via per-entry valid bits, no
//   clearing pass), periods to their defaults, prescaler and pins to zero.
// Stall: a stalled result holds in the output register and in_stall_o stays
//   high until it drains.
module periodic_task_dispatch_timer #(
  parameter int unsigned NUM_CHANNELS   = 8,
  parameter int unsigned TICKS_PER_SCAN = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        tick_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        scan_done_o,
  output logic [ptd_pkg::ChMax-1:0]   fired_mask_o,
  output logic [ptd_pkg::PinW-1:0]    pin_levels_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ptd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ptd_pkg::CntW-1:0]    cfg_data_i
);
  import ptd_pkg::*;

  period_arr_t     period_q;
  mem_req_t        mem_req;
  logic [CntW-1:0] rd_data;
  result_t         res;
  ctrl_status_t    status;
  logic            slot_free;

  logic             out_valid_q;
  logic             scan_done_q;
  logic [ChMax-1:0] mask_q;
  logic [PinW-1:0]  pins_q;

  // Period registers; writes beyond the register list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodRst;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgIdxW'(ChMax))) begin
      period_q[cfg_index_i[ChW-1:0]] <= cfg_data_i;
    end
  end

  ptd_cnt_mem u_cnt_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output slot is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  ptd_scan_ctrl #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .TICKS_PER_SCAN (TICKS_PER_SCAN)
  ) u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .tick_i      (tick_i),
    .slot_free_i (slot_free),
    .in_stall_o  (in_stall_o),
    .period_i    (period_q),
    .rd_data_i   (rd_data),
    .req_o       (mem_req),
    .res_o       (res),
    .status_o    (status)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      scan_done_q <= res.scan_done;
      mask_q      <= res.mask;
      pins_q      <= res.pins;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scan_done_o  = scan_done_q;
  assign fired_mask_o = mask_q;
  assign pin_levels_o = pins_q;

  // A result without a scan never reports fired channels.
  a_no_scan_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !scan_done_o) |-> (fired_mask_o == '0))
    else $error("fired mask set without a scan");

  // Channels above the configured count never fire.
  a_unused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((fired_mask_o >> NUM_CHANNELS) == '0))
    else $error("unused channel fired");

  // No new beat is taken while a scan is running.
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> in_stall_o)
    else $error("input accepted during scan");

  // The output register is never overwritten while a beat is stalled in it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res.valid)
    else $error("stalled result overwritten");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the periodic task dispatch timer: scheduler model, result checker, stimulus.
`timescale 1ns / 1ps

module tb_top;
  import ptd_pkg::*;

  localparam int unsigned NumCh        = 8;
  localparam int unsigned TicksPerScan = 10;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned NumDirRows   = 22;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned RandItems    = 1878;
  // Leave some slack for stray beats after the last scan.
  localparam int unsigned DrainCycles  = NumCh + 12;
  localparam int unsigned LimitNs      = 2000000;
  localparam int unsigned TickPct      = 85;

  // Phases of the random part with a fixed purpose.
  localparam int unsigned PhaseAllOnes = 0;
  localparam int unsigned PhaseLongCh  = 4;
  localparam int unsigned PhaseStopCh  = NumPhases - 1;
  // Channels that get the long and the zero periods.
  localparam int unsigned LongCh       = 3;
  localparam int unsigned StopChA      = 1;
  localparam int unsigned StopChB      = 6;
  // Only this channel ever draws a long random period, so the stop channels
  // are guaranteed to count out during the last phase.
  localparam int unsigned WideCh       = 7;

  // One result beat as the scheduler sees it.
  typedef struct packed {
    logic               done;
    logic [ChMax-1:0]   mask;
    logic [PinW-1:0]    pins;
  } dispatch_t;

  // Directed row: tick value, whether the result is typed in, and that result.
  typedef struct packed {
    logic      tick;
    logic      typed;
    dispatch_t res;
  } tick_row_t;

  // Reset sequence: first scan on tick 10 decrements the primes (nothing
  // fires), second scan on tick 20 brings channel 0 from 2 down to zero.
  // Idle beats (tick 0) in between must hold everything.
  localparam tick_row_t DirRows [NumDirRows] = '{
    '{1'b0, 1'b1, '{1'b0, 8'h00, 6'h00}},  // no tick right out of reset
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b1, '{1'b1, 8'h00, 6'h00}},  // tick 10: first scan, no fire
    '{1'b0, 1'b1, '{1'b0, 8'h00, 6'h00}},  // no tick mid-period
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b0, '{1'b0, 8'h00, 6'h00}},
    '{1'b1, 1'b1, '{1'b1, 8'h01, 6'h00}}   // tick 20: channel 0 fires
  };

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                tick_i       = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                scan_done_o;
  logic [ChMax-1:0]    fired_mask_o;
  logic [PinW-1:0]     pin_levels_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CntW-1:0]     cfg_data_i   = '0;

  // Scheduler model state: period registers, countdowns, prescaler, pins.
  logic [CntW-1:0]     reload_val [NumRegs];
  logic [CntW-1:0]     ch_count   [NumCh];
  logic [PscW-1:0]     prescale;
  logic [PinW-1:0]     pin_lvl;
  // Periods to program at the next phase boundary.
  logic [CntW-1:0]     next_period [NumRegs];

  dispatch_t           pending_dispatch [$];
  int unsigned         mismatch_cnt   = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;

  periodic_task_dispatch_timer #(
    .NUM_CHANNELS   (NumCh),
    .TICKS_PER_SCAN (TicksPerScan)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tick_i       (tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scan_done_o  (scan_done_o),
    .fired_mask_o (fired_mask_o),
    .pin_levels_o (pin_levels_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #(LimitNs);
    $display("periodic_task_dispatch_timer test failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // One tick beat through the scheduler: prescaler, then a scan over all
  // channels in index order when the period wraps.
  function automatic dispatch_t advance_schedule(input logic tick);
    dispatch_t r;
    r = '0;
    if (tick) begin
      if (int'(prescale) + 1 >= TicksPerScan) begin
        prescale = '0;
        r.done   = 1'b1;
        for (int ch = 0; ch < NumCh; ch++) begin
          // A channel sitting at zero is stopped and gets skipped.
          if (ch_count[ch] != '0) begin
            ch_count[ch] = ch_count[ch] - 1'b1;
            if (ch_count[ch] == '0) begin
              r.mask[ch]   = 1'b1;
              ch_count[ch] = reload_val[ch];
              // Channels 0 and 1 drive no pin.
              if (ch >= 2) pin_lvl[ch-2] = ~pin_lvl[ch-2];
            end
          end
        end
      end else begin
        prescale = prescale + 1'b1;
      end
    end
    r.pins = pin_lvl;
    return r;
  endfunction

  // Present one input beat, hold it through stalls, then log what it should
  // produce. Typed rows override the model's answer.
  task automatic send_tick(input logic t, input logic typed, input dispatch_t typed_res);
    dispatch_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_schedule(t);
    pending_dispatch.push_back(typed ? typed_res : pred);
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dispatch.size() != 0) @(posedge clk_i);
  endtask

  // Back-to-back writes of all period registers from next_period, then one
  // write to an index past the list, which the block must drop.
  task automatic program_periods(input logic [CfgIdxW-1:0] stray_idx,
                                 input logic [CntW-1:0] stray_data);
    for (int i = 0; i <= NumRegs; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == NumRegs) ? stray_idx : CfgIdxW'(i);
      cfg_data_i  <= (i == NumRegs) ? stray_data : next_period[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (i < NumRegs) reload_val[i] = next_period[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stall, and every accepted beat is compared against
  // the oldest pending expectation.
  always @(posedge clk_i) begin
    dispatch_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_dispatch.size() == 0) begin
          flag_mismatch("result beat with nothing pending");
        end else begin
          want = pending_dispatch.pop_front();
          if (scan_done_o !== want.done)
            flag_mismatch($sformatf("scan_done %b, want %b", scan_done_o, want.done));
          if (fired_mask_o !== want.mask)
            flag_mismatch($sformatf("fired_mask %h, want %h", fired_mask_o, want.mask));
          if (pin_levels_o !== want.pins)
            flag_mismatch($sformatf("pin_levels %h, want %h", pin_levels_o, want.pins));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    logic [CfgIdxW-1:0] stray_idx;

    // Model starts from the reset image of the block.
    for (int i = 0; i < NumCh; i++) begin
      reload_val[i] = PeriodRst[i];
      ch_count[i]   = StartCount[i];
    end
    prescale = '0;
    pin_lvl  = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset countdowns, idle beats, first two scans.
    send_idle_pct  = 20;
    recv_stall_pct = 45;
    for (int r = 0; r < NumDirRows; r++)
      send_tick(DirRows[r].tick, DirRows[r].typed, DirRows[r].res);

    // Random phases, each opened by a full reprogram while the block is
    // idle. First phase pins every period at the low extreme so all channels fire
    // each scan once their countdowns run out; a later one parks a pin channel at
    // the high extreme; the last one stops two channels with a zero period.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      for (int i = 0; i < NumRegs; i++) begin
        if (p == PhaseAllOnes)
          next_period[i] = 8'd1;
        else if (i == WideCh && $urandom_range(3) == 0)
          next_period[i] = CntW'($urandom_range(13, 254));
        else
          next_period[i] = CntW'($urandom_range(1, 12));
      end
      if (p == PhaseLongCh) next_period[LongCh] = '1;
      if (p == PhaseStopCh) begin
        next_period[StopChA] = '0;
        next_period[StopChB] = '0;
      end
      stray_idx = (p == PhaseAllOnes) ? '1 : CfgIdxW'($urandom_range(NumRegs, 15));
      program_periods(stray_idx, CntW'($urandom));

      // Receiver-heavy stalling, then sender-heavy idling, then full rate.
      if (p < 2) begin
        send_idle_pct  = 20;
        recv_stall_pct = 45;
      end else if (p < 4) begin
        send_idle_pct  = 45;
        recv_stall_pct = 20;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      repeat (RandItems / NumPhases)
        send_tick($urandom_range(99) < TickPct, 1'b0, '0);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_dispatch.size() == 0) begin
      $display("periodic_task_dispatch_timer test passed");
    end else begin
      $display("periodic_task_dispatch_timer test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_cnt_mem.sv
hw/rtl/ptd_scan_ctrl.sv
hw/rtl/periodic_task_dispatch_timer.sv
verif/tb_top.sv
